// File: src/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the lidar scan packet receiver.
// ----------------------------------------------------------------------------
package lpr_pkg;

   // Fixed packet geometry
   localparam int HEADER_BYTES     = 10;   // header, type, count, angles, checksum
   localparam int BYTES_PER_SAMPLE = 3;
   localparam int NEED_W           = 11;   // width of count * 3 + 10 and of the buffer size

   // Register reset values
   localparam logic [7:0] HEADER_LOW_RESET  = 8'hAA;
   localparam logic [7:0] HEADER_HIGH_RESET = 8'h55;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 2;
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_LOW  = 2'd0,
      CSR_HEADER_HIGH = 2'd1
   } csr_index_type;

   // Parse phases
   typedef enum logic [3:0] {
      PH_HUNT_LOW   = 4'd0,
      PH_HUNT_HIGH  = 4'd1,
      PH_TYPE       = 4'd2,
      PH_COUNT      = 4'd3,
      PH_START_LO   = 4'd4,
      PH_START_HI   = 4'd5,
      PH_END_LO     = 4'd6,
      PH_END_HI     = 4'd7,
      PH_CHECK_LO   = 4'd8,
      PH_CHECK_HI   = 4'd9,
      PH_SAMPLES    = 4'd10
   } phase_type;

   // Position of a byte inside one sample
   typedef enum logic [1:0] {
      SB_INTENSITY = 2'd0,
      SB_DIST_LOW  = 2'd1,
      SB_DIST_HIGH = 2'd2
   } sample_byte_type;

   // One decoded sample
   typedef struct packed {
      logic [6:0]  sample_index;
      logic [6:0]  sample_count;
      logic [7:0]  packet_type;
      logic [14:0] start_angle_code;
      logic [14:0] end_angle_code;
      logic [7:0]  intensity;
      logic [13:0] distance;
      logic        last_sample;
      logic        checksum_ok;
   } sample_type;

   // Output queue status
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// File: src/lpr_if.sv
// ----------------------------------------------------------------------------
// lpr_if
// Valid/ready channels of the lidar scan packet receiver.
// ----------------------------------------------------------------------------

// Received byte stream
interface lpr_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// Decoded samples
interface lpr_sample_if;
   logic        valid;
   logic        ready;
   logic [6:0]  sample_index;
   logic [6:0]  sample_count;
   logic [7:0]  packet_type;
   logic [14:0] start_angle_code;
   logic [14:0] end_angle_code;
   logic [7:0]  intensity;
   logic [13:0] distance;
   logic        last_sample;
   logic        checksum_ok;

   modport source (output valid, output sample_index, output sample_count,
                   output packet_type, output start_angle_code, output end_angle_code,
                   output intensity, output distance, output last_sample,
                   output checksum_ok, input ready);
   modport sink   (input valid, input sample_index, input sample_count,
                   input packet_type, input start_angle_code, input end_angle_code,
                   input intensity, input distance, input last_sample,
                   input checksum_ok, output ready);
endinterface

// Configuration writes
interface lpr_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/lpr_parser.sv
// ----------------------------------------------------------------------------
// lpr_parser
// Packet state machine: one byte per advance, header hunt, checksum XOR and
// sample decode.
// ----------------------------------------------------------------------------
module lpr_parser #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic [7:0]         rx_byte,
   input  logic [7:0]         header_low,
   input  logic [7:0]         header_high,
   output logic               res_valid,
   output lpr_pkg::sample_type res
);
   import lpr_pkg::*;

   phase_type       phase_ff, phase_in;
   sample_byte_type bis_ff, bis_in;
   logic [6:0]      count_ff, count_in;
   logic [6:0]      sctr_ff, sctr_in;
   logic [7:0]      type_ff, type_in;
   logic [15:0]     start_ff, start_in;
   logic [15:0]     end_ff, end_in;
   logic [15:0]     check_ff, check_in;
   logic [15:0]     xor_ff, xor_in;
   logic [7:0]      inten_ff, inten_in;
   logic [7:0]      dlow_ff, dlow_in;

   logic [NEED_W-1:0] need;
   logic              count_bad;
   logic              last;
   logic [15:0]       xor_final;

   // Count byte check: zero, above 127, or too large for the buffer
   assign need      = {3'b000, rx_byte} + {2'b00, rx_byte, 1'b0} + NEED_W'(HEADER_BYTES);
   assign count_bad = (rx_byte == 8'd0) || rx_byte[7] || (need >= NEED_W'(BUFFER_BYTES));

   assign last      = ({1'b0, sctr_ff} + 8'd1) >= {1'b0, count_ff};
   assign xor_final = xor_ff ^ {8'd0, inten_ff} ^ {rx_byte, dlow_ff};

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_HUNT_LOW:  if (rx_byte == header_low)  phase_in = PH_HUNT_HIGH;
         PH_HUNT_HIGH: if (rx_byte == header_high) phase_in = PH_TYPE;
         PH_TYPE:      phase_in = PH_COUNT;
         PH_COUNT:     phase_in = count_bad ? PH_HUNT_LOW : PH_START_LO;
         PH_START_LO:  phase_in = PH_START_HI;
         PH_START_HI:  phase_in = PH_END_LO;
         PH_END_LO:    phase_in = PH_END_HI;
         PH_END_HI:    phase_in = PH_CHECK_LO;
         PH_CHECK_LO:  phase_in = PH_CHECK_HI;
         PH_CHECK_HI:  phase_in = PH_SAMPLES;
         PH_SAMPLES:   if (bis_ff == SB_DIST_HIGH && last) phase_in = PH_HUNT_LOW;
         default:      phase_in = PH_HUNT_LOW;
      endcase
   end

   // Field capture, checksum and result
   always_comb begin
      bis_in    = bis_ff;
      count_in  = count_ff;
      sctr_in   = sctr_ff;
      type_in   = type_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      check_in  = check_ff;
      xor_in    = xor_ff;
      inten_in  = inten_ff;
      dlow_in   = dlow_ff;
      res_valid = 1'b0;

      res.sample_index     = sctr_ff;
      res.sample_count     = count_ff;
      res.packet_type      = type_ff;
      res.start_angle_code = start_ff[15:1];
      res.end_angle_code   = end_ff[15:1];
      res.intensity        = inten_ff;
      res.distance         = {rx_byte, dlow_ff[7:2]};
      res.last_sample      = last;
      res.checksum_ok      = last && (xor_final == check_ff);

      case (phase_ff)
         PH_HUNT_LOW:  if (rx_byte == header_low) xor_in = {8'd0, rx_byte};
         PH_HUNT_HIGH: if (rx_byte == header_high) xor_in = xor_ff ^ {rx_byte, 8'd0};
         PH_TYPE:      type_in = rx_byte;
         PH_COUNT: begin
            if (!count_bad) begin
               count_in = rx_byte[6:0];
               xor_in   = xor_ff ^ {rx_byte, type_ff};
               sctr_in  = 7'd0;
               bis_in   = SB_INTENSITY;
            end
         end
         PH_START_LO:  start_in = {8'd0, rx_byte};
         PH_START_HI: begin
            start_in = {rx_byte, start_ff[7:0]};
            xor_in   = xor_ff ^ {rx_byte, start_ff[7:0]};
         end
         PH_END_LO:    end_in = {8'd0, rx_byte};
         PH_END_HI: begin
            end_in = {rx_byte, end_ff[7:0]};
            xor_in = xor_ff ^ {rx_byte, end_ff[7:0]};
         end
         PH_CHECK_LO:  check_in = {8'd0, rx_byte};
         PH_CHECK_HI:  check_in = {rx_byte, check_ff[7:0]};
         PH_SAMPLES: begin
            case (bis_ff)
               SB_INTENSITY: begin
                  inten_in = rx_byte;
                  bis_in   = SB_DIST_LOW;
               end
               SB_DIST_LOW: begin
                  dlow_in = rx_byte;
                  bis_in  = SB_DIST_HIGH;
               end
               default: begin
                  // emit the completed sample
                  xor_in    = xor_final;
                  res_valid = 1'b1;
                  bis_in    = SB_INTENSITY;
                  sctr_in   = last ? 7'd0 : sctr_ff + 7'd1;
               end
            endcase
         end
         default: ;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT_LOW;
         bis_ff   <= SB_INTENSITY;
         sctr_ff  <= 7'd0;
         count_ff <= 7'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         bis_ff   <= bis_in;
         sctr_ff  <= sctr_in;
         count_ff <= count_in;
      end
   end

   // Packet fields and checksum
   always_ff @(posedge clock) begin
      if (advance) begin
         type_ff  <= type_in;
         start_ff <= start_in;
         end_ff   <= end_in;
         check_ff <= check_in;
         xor_ff   <= xor_in;
         inten_ff <= inten_in;
         dlow_ff  <= dlow_in;
      end
   end

endmodule

// File: src/lpr_out_queue.sv
// ----------------------------------------------------------------------------
// lpr_out_queue
// Two-entry result queue between the parser and the sample channel.
// ----------------------------------------------------------------------------
module lpr_out_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  lpr_pkg::sample_type      push_data,
   input  logic                     pop,
   output lpr_pkg::sample_type      head,
   output lpr_pkg::queue_status_type status
);
   import lpr_pkg::*;

   sample_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign do_push = push && (count_ff != 2'd2);
   assign do_pop  = pop && (count_ff != 2'd0);

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed sample
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

// File: src/lidar_packet_receiver.sv
// ----------------------------------------------------------------------------
// lidar_packet_receiver
// Byte-serial scan packet parser: header hunt, length check, XOR checksum and
// one decoded sample per completed three-byte sample group.
// ----------------------------------------------------------------------------
// A sample's last byte is held in the input register, then its decoded sample is
// written into the output queue, whose head drives rsp. Throughput: one byte per
// cycle while the queue has room; the parser state update is the only loop. Up to
// two decoded samples are held while the sink stalls. Reset: parser returns to the
// header hunt, the queue empties, header registers load 0xAA and 0x55.
module lidar_packet_receiver #(
   parameter int BUFFER_BYTES = 256
) (
   input  logic               clock,
   input  logic               reset,
   lpr_byte_if.sink           req_chan,
   lpr_sample_if.source       rsp_chan,
   lpr_csr_if.sink            csr_chan
);
   import lpr_pkg::*;

   logic [7:0]       hdr_low_ff, hdr_high_ff;
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             advance;
   logic             res_valid;
   sample_type       res;
   sample_type       head;
   queue_status_type q_status;

   // Configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_low_ff  <= HEADER_LOW_RESET;
         hdr_high_ff <= HEADER_HIGH_RESET;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_HEADER_LOW:  hdr_low_ff  <= csr_chan.data;
            CSR_HEADER_HIGH: hdr_high_ff <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Input register: advance into the parser while the queue has room
   assign advance        = in_valid_ff && !q_status.full;
   assign req_chan.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.rx_byte;
      end
   end

   lpr_parser #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .rx_byte     (in_byte_ff),
      .header_low  (hdr_low_ff),
      .header_high (hdr_high_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   lpr_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && res_valid),
      .push_data (res),
      .pop       (rsp_chan.ready),
      .head      (head),
      .status    (q_status)
   );

   // Drive the sample channel from the queue head
   assign rsp_chan.valid            = !q_status.empty;
   assign rsp_chan.sample_index     = head.sample_index;
   assign rsp_chan.sample_count     = head.sample_count;
   assign rsp_chan.packet_type      = head.packet_type;
   assign rsp_chan.start_angle_code = head.start_angle_code;
   assign rsp_chan.end_angle_code   = head.end_angle_code;
   assign rsp_chan.intensity        = head.intensity;
   assign rsp_chan.distance         = head.distance;
   assign rsp_chan.last_sample      = head.last_sample;
   assign rsp_chan.checksum_ok      = head.checksum_ok;

   // The parser never advances into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      advance |-> !q_status.full)
      else $error("parser advanced into a full queue");

   // The last sample is exactly the one whose index closes the announced count
   a_last_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.last_sample ==
         (({1'b0, rsp_chan.sample_index} + 8'd1) == {1'b0, rsp_chan.sample_count})))
      else $error("last_sample disagrees with sample index and count");

   // A checksum verdict only rides on the last sample
   a_check_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.checksum_ok |-> rsp_chan.last_sample)
      else $error("checksum_ok set on a sample that is not the last");

   // A sample pushed by the parser is held in the queue after the push
   a_push_needs_byte: assert property (@(posedge clock) disable iff (reset)
      advance && res_valid |=> !q_status.empty)
      else $error("pushed sample missing from the queue");

endmodule

// File: tb/sv/lidar_packet_receiver_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_packet_receiver_test
// Drives scan packet byte streams into the receiver under several header
// settings. A built-in parser predicts every decoded sample and each transfer
// on the sample channel is compared with it, field by field.
// ----------------------------------------------------------------------------
module lidar_packet_receiver_test;
   import lpr_pkg::*;

   localparam int BUFFER_SIZE     = 256;
   localparam int SETTLE_CYCLES   = 8;        // covers the input register and the output queue
   localparam int DRAIN_LIMIT     = 20000;
   localparam int BYTES_PER_SET   = 205;      // minimum consumed bytes per header setting
   localparam int NUM_SETTINGS    = 6;
   localparam longint RUN_LIMIT_NS = 2_000_000;

   // -------------------------------------------------------------------------
   // Packet parser prediction and sample checking
   // -------------------------------------------------------------------------
   class sample_scoreboard;
      logic [7:0]      hdr_low, hdr_high;
      phase_type       stage;
      sample_byte_type sbyte;
      logic [6:0]      count_hold, sample_idx;
      logic [7:0]      type_hold, intensity_hold, dist_low_hold;
      logic [15:0]     first_bearing, last_bearing, check_word, xor_acc;
      sample_type      awaited_samples[$];
      int mismatches, samples_checked, good_packets, bad_packets, dropped_packets;

      function new();
         hdr_low = HEADER_LOW_RESET;
         hdr_high = HEADER_HIGH_RESET;
         stage = PH_HUNT_LOW;
         sbyte = SB_INTENSITY;
         count_hold = '0;
         sample_idx = '0;
         type_hold = '0;
         intensity_hold = '0;
         dist_low_hold = '0;
         first_bearing = '0;
         last_bearing = '0;
         check_word = '0;
         xor_acc = '0;
         mismatches = 0;
         samples_checked = 0;
         good_packets = 0;
         bad_packets = 0;
         dropped_packets = 0;
      endfunction

      function void set_header(csr_index_type idx, logic [7:0] value);
         if (idx == CSR_HEADER_LOW) begin
            hdr_low = value;
         end else if (idx == CSR_HEADER_HIGH) begin
            hdr_high = value;
         end
      endfunction

      // Advance the parser by one byte; returns 0 when the byte was ignored
      function bit note_byte(logic [7:0] b);
         int          need;
         logic [15:0] dist_word;
         sample_type  s;
         bit          ends;
         case (stage)
            PH_HUNT_LOW: begin
               if (b != hdr_low) return 1'b0;
               xor_acc = {8'h00, b};
               stage = PH_HUNT_HIGH;
            end
            PH_HUNT_HIGH: begin
               // hold in this phase until the second header byte shows up
               if (b != hdr_high) return 1'b0;
               xor_acc = xor_acc ^ {b, 8'h00};
               stage = PH_TYPE;
            end
            PH_TYPE: begin
               type_hold = b;
               stage = PH_COUNT;
            end
            PH_COUNT: begin
               need = int'(b) * BYTES_PER_SAMPLE + HEADER_BYTES;
               if (b == 8'd0 || b > 8'd127 || need >= BUFFER_SIZE) begin
                  // empty or oversized: drop and hunt again
                  dropped_packets++;
                  stage = PH_HUNT_LOW;
               end else begin
                  count_hold = b[6:0];
                  xor_acc = xor_acc ^ {b, type_hold};
                  sample_idx = '0;
                  sbyte = SB_INTENSITY;
                  stage = PH_START_LO;
               end
            end
            PH_START_LO: begin
               first_bearing = {8'h00, b};
               stage = PH_START_HI;
            end
            PH_START_HI: begin
               first_bearing[15:8] = b;
               xor_acc = xor_acc ^ first_bearing;
               stage = PH_END_LO;
            end
            PH_END_LO: begin
               last_bearing = {8'h00, b};
               stage = PH_END_HI;
            end
            PH_END_HI: begin
               last_bearing[15:8] = b;
               xor_acc = xor_acc ^ last_bearing;
               stage = PH_CHECK_LO;
            end
            PH_CHECK_LO: begin
               check_word = {8'h00, b};
               stage = PH_CHECK_HI;
            end
            PH_CHECK_HI: begin
               check_word[15:8] = b;
               stage = PH_SAMPLES;
            end
            PH_SAMPLES: begin
               case (sbyte)
                  SB_INTENSITY: begin
                     intensity_hold = b;
                     sbyte = SB_DIST_LOW;
                  end
                  SB_DIST_LOW: begin
                     dist_low_hold = b;
                     sbyte = SB_DIST_HIGH;
                  end
                  default: begin
                     // third byte completes the sample
                     dist_word = {b, dist_low_hold};
                     xor_acc = xor_acc ^ {8'h00, intensity_hold} ^ dist_word;
                     ends = (int'(sample_idx) + 1 >= int'(count_hold));
                     s.sample_index     = sample_idx;
                     s.sample_count     = count_hold;
                     s.packet_type      = type_hold;
                     s.start_angle_code = first_bearing[15:1];
                     s.end_angle_code   = last_bearing[15:1];
                     s.intensity        = intensity_hold;
                     s.distance         = {b, dist_low_hold[7:2]};
                     s.last_sample      = ends;
                     s.checksum_ok      = ends && (xor_acc == check_word);
                     awaited_samples.push_back(s);
                     sbyte = SB_INTENSITY;
                     if (ends) begin
                        if (s.checksum_ok) good_packets++;
                        else bad_packets++;
                        stage = PH_HUNT_LOW;
                        sample_idx = '0;
                     end else begin
                        sample_idx = sample_idx + 7'd1;
                     end
                  end
               endcase
            end
            default: stage = PH_HUNT_LOW;
         endcase
         return 1'b1;
      endfunction

      task report(string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task cmp_field(string name, int got_v, int exp_v, int idx);
         if (got_v != exp_v) begin
            report($sformatf("sample %0d field %s: got 0x%0h, expected 0x%0h",
                             idx, name, got_v, exp_v));
         end
      endtask

      task check_sample(sample_type got);
         sample_type exp_s;
         if (awaited_samples.size() == 0) begin
            report($sformatf("unexpected sample, index %0d distance 0x%0h",
                             got.sample_index, got.distance));
            return;
         end
         exp_s = awaited_samples.pop_front();
         cmp_field("sample_index", got.sample_index, exp_s.sample_index, samples_checked);
         cmp_field("sample_count", got.sample_count, exp_s.sample_count, samples_checked);
         cmp_field("packet_type", got.packet_type, exp_s.packet_type, samples_checked);
         cmp_field("start_angle_code", got.start_angle_code, exp_s.start_angle_code,
                   samples_checked);
         cmp_field("end_angle_code", got.end_angle_code, exp_s.end_angle_code,
                   samples_checked);
         cmp_field("intensity", got.intensity, exp_s.intensity, samples_checked);
         cmp_field("distance", got.distance, exp_s.distance, samples_checked);
         cmp_field("last_sample", got.last_sample, exp_s.last_sample, samples_checked);
         cmp_field("checksum_ok", got.checksum_ok, exp_s.checksum_ok, samples_checked);
         samples_checked++;
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, channels and the block
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   lpr_byte_if   req_bus();
   lpr_sample_if rsp_bus();
   lpr_csr_if    csr_bus();

   lidar_packet_receiver #(
      .BUFFER_BYTES (BUFFER_SIZE)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   sample_scoreboard board = new();

   logic [7:0]  tx_q[$];
   logic [15:0] ready_shape = 16'hFFFF;
   logic [3:0]  ready_tick = '0;
   int          gap_max = 0;
   int          burst_left = 0;
   int          consumed = 0;
   int          settings_done = 0;
   sample_type  rsp_word;

   assign rsp_word = {rsp_bus.sample_index, rsp_bus.sample_count, rsp_bus.packet_type,
                      rsp_bus.start_angle_code, rsp_bus.end_angle_code,
                      rsp_bus.intensity, rsp_bus.distance, rsp_bus.last_sample,
                      rsp_bus.checksum_ok};

   // Sink stall pattern, rotated every cycle
   always @(negedge clock) begin
      rsp_bus.ready <= ready_shape[ready_tick];
      ready_tick <= ready_tick + 4'd1;
   end

   // Check each sample transfer
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         board.check_sample(rsp_word);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------
   function automatic logic [15:0] draw_word();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0) return 16'h0000;
      if (r == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic int draw_count();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 6);
      if (r < 97) return $urandom_range(7, 40);
      return $urandom_range(41, 81);
   endfunction

   // Queue one packet; fill < 0 gives random sample bytes, else every sample
   // byte takes that value. junk inserts wrong second header bytes.
   task automatic build_packet(input logic [7:0] ptype, input int count,
                               input logic [15:0] sa, input logic [15:0] ea,
                               input bit bad_check, input int junk, input int fill);
      logic [7:0]  body[$];
      logic [15:0] acc, dw;
      logic [7:0]  inten, v;
      acc = {board.hdr_high, board.hdr_low} ^ {8'(count), ptype} ^ sa ^ ea;
      for (int i = 0; i < count; i++) begin
         if (fill < 0) begin
            inten = 8'(draw_word());
            dw = draw_word();
         end else begin
            inten = 8'(fill);
            dw = {8'(fill), 8'(fill)};
         end
         acc = acc ^ {8'h00, inten} ^ dw;
         body.push_back(inten);
         body.push_back(dw[7:0]);
         body.push_back(dw[15:8]);
      end
      if (bad_check) acc = acc ^ 16'($urandom_range(1, 65535));
      tx_q.push_back(board.hdr_low);
      for (int j = 0; j < junk; j++) begin
         do v = 8'($urandom); while (v == board.hdr_high);
         tx_q.push_back(v);
      end
      tx_q.push_back(board.hdr_high);
      tx_q.push_back(ptype);
      tx_q.push_back(8'(count));
      tx_q.push_back(sa[7:0]);
      tx_q.push_back(sa[15:8]);
      tx_q.push_back(ea[7:0]);
      tx_q.push_back(ea[15:8]);
      tx_q.push_back(acc[7:0]);
      tx_q.push_back(acc[15:8]);
      foreach (body[k]) tx_q.push_back(body[k]);
   endtask

   task automatic build_bad_count(input logic [7:0] count);
      tx_q.push_back(board.hdr_low);
      tx_q.push_back(board.hdr_high);
      tx_q.push_back(8'($urandom));
      tx_q.push_back(count);
   endtask

   // One byte transfer, sender in bursts with random gaps; call at a falling edge
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (board.note_byte(b)) consumed++;
      @(negedge clock);
   endtask

   task automatic send_queued();
      while (tx_q.size() != 0) send_byte(tx_q.pop_front());
   endtask

   // Hold until every awaited sample has arrived, then let the pipeline settle
   task automatic drain();
      int guard;
      guard = 0;
      req_bus.valid <= 1'b0;
      while (board.awaited_samples.size() != 0 && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_headers(input logic [7:0] lo, input logic [7:0] hi);
      csr_index_type idx;
      for (int i = 0; i < 2; i++) begin
         idx = (i == 0) ? CSR_HEADER_LOW : CSR_HEADER_HIGH;
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx;
         csr_bus.data <= (i == 0) ? lo : hi;
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
         board.set_header(idx, (i == 0) ? lo : hi);
         @(negedge clock);
      end
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_item();
      int          pick, cut;
      logic [7:0]  cnt;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         build_packet(8'($urandom), draw_count(), draw_word(), draw_word(), 1'b0, 0, -1);
      end else if (pick < 70) begin
         build_packet(8'($urandom), draw_count(), draw_word(), draw_word(), 1'b1, 0, -1);
      end else if (pick < 77) begin
         build_packet(8'($urandom), draw_count(), draw_word(), draw_word(),
                      1'($urandom), $urandom_range(1, 3), -1);
      end else if (pick < 85) begin
         case ($urandom_range(0, 4))
            0: cnt = 8'd0;
            1: cnt = 8'd82;
            2: cnt = 8'd127;
            3: cnt = 8'd128;
            default: cnt = 8'($urandom_range(82, 255));
         endcase
         build_bad_count(cnt);
      end else if (pick < 93) begin
         repeat ($urandom_range(1, 8)) tx_q.push_back(8'($urandom));
      end else if (pick < 96) begin
         // truncated packet: the following bytes are taken as its tail
         build_packet(8'($urandom), draw_count(), draw_word(), draw_word(), 1'b0, 0, -1);
         cut = $urandom_range(1, tx_q.size() - 1);
         while (tx_q.size() > cut) void'(tx_q.pop_back());
      end else begin
         build_packet(8'($urandom), ($urandom_range(0, 1) != 0) ? 81 : 1,
                      draw_word(), draw_word(), 1'($urandom), 0,
                      ($urandom_range(0, 1) != 0) ? 0 : 255);
      end
      send_queued();
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   logic [7:0] low_set[NUM_SETTINGS];
   logic [7:0] high_set[NUM_SETTINGS];

   initial begin
      req_bus.valid = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_HEADER_LOW;
      csr_bus.data = '0;
      low_set = '{8'hAA, 8'h00, 8'hFF, 8'h00, 8'($urandom), 8'hAA};
      high_set = '{8'h55, 8'h00, 8'hFF, 8'hFF, 8'($urandom), 8'h55};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty packet, oversized packet, then a one-sample packet
      // behind a wrong second header byte with all fields at their extremes
      build_bad_count(8'd0);
      build_bad_count(8'd82);
      build_packet(8'hFF, 1, 16'hFFFF, 16'h0000, 1'b0, 1, 255);
      send_queued();

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         drain();
         if (s != 0) write_headers(low_set[s], high_set[s]);
         // first setting runs without any idling on either side
         if (s == 0) begin
            gap_max = 0;
            ready_shape = 16'hFFFF;
         end else begin
            gap_max = $urandom_range(1, 6);
            ready_shape = 16'($urandom) | 16'h0001;
         end
         consumed = 0;
         if (s == 1 || s == 3) begin
            build_packet(8'($urandom), 81, draw_word(), draw_word(), 1'b0, 0, -1);
            send_queued();
         end
         while (consumed < BYTES_PER_SET) random_item();
         settings_done++;
      end

      drain();
      if (board.awaited_samples.size() != 0) begin
         board.report($sformatf("%0d samples never arrived", board.awaited_samples.size()));
      end
      $display("Covered %0d header settings, %0d samples checked.",
               settings_done, board.samples_checked);
      $display("Packets: %0d checksum good, %0d checksum bad, %0d dropped for length.",
               board.good_packets, board.bad_packets, board.dropped_packets);
      if (board.mismatches == 0) begin
         $display("lidar_packet_receiver test passed");
      end else begin
         $display("lidar_packet_receiver test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout: run did not complete");
      $display("lidar_packet_receiver test failed");
      $finish;
   end

endmodule
